FILE: rtl/sfpf8_pkg.sv
`default_nettype none
package sfpf8_pkg;

	// parser phases; codes beyond checksum b act as hunting the first byte
	typedef enum logic [3:0] {
		PH_HUNT_FIRST  = 4'd0,
		PH_HUNT_SECOND = 4'd1,
		PH_CLASS       = 4'd2,
		PH_ID          = 4'd3,
		PH_LEN_LO      = 4'd4,
		PH_LEN_HI      = 4'd5,
		PH_PAYLOAD     = 4'd6,
		PH_CK_A        = 4'd7,
		PH_CK_B        = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		ST_NOTHING  = 3'd0,
		ST_PAYLOAD  = 3'd1,
		ST_GOOD     = 3'd2,
		ST_CK_A_BAD = 3'd3,
		ST_CK_B_BAD = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
	localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST   = 8'd181;
	localparam logic [7:0]  SYNC_SECOND_RST  = 8'd98;
	localparam logic [15:0] LENGTH_LIMIT_RST = 16'd1024;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] length_limit;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic        payload_kept;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/sfpf8_cfg_regs.sv
`default_nettype none
module sfpf8_cfg_regs
	import sfpf8_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first   <= SYNC_FIRST_RST;
			cfg_q.sync_second  <= SYNC_SECOND_RST;
			cfg_q.length_limit <= LENGTH_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_FIRST:   cfg_q.sync_first   <= pwdata[7:0];
				REG_SYNC_SECOND:  cfg_q.sync_second  <= pwdata[7:0];
				REG_LENGTH_LIMIT: cfg_q.length_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYNC_FIRST:   prdata = {24'd0, cfg_q.sync_first};
			REG_SYNC_SECOND:  prdata = {24'd0, cfg_q.sync_second};
			REG_LENGTH_LIMIT: prdata = {16'd0, cfg_q.length_limit};
			default:          prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/sfpf8_parser.sv
`default_nettype none
module sfpf8_parser
	import sfpf8_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output res_t            res
);

	phase_t      phase_q,  phase_n;
	logic [7:0]  sum_a_q,  sum_a_n;
	logic [7:0]  sum_b_q,  sum_b_n;
	logic [7:0]  class_q,  class_n;
	logic [7:0]  id_q,     id_n;
	logic [15:0] length_q, length_n;
	logic [15:0] count_q,  count_n;

	logic [7:0]  add_a;
	logic [7:0]  add_b;
	logic [15:0] new_len;
	logic [15:0] count_inc;
	logic        kept;
	phase_t      hunt_phase;

	// fletcher running sums with the incoming byte
	assign add_a      = sum_a_q + rx_byte;
	assign add_b      = sum_b_q + add_a;
	assign new_len    = {rx_byte, length_q[7:0]};
	assign count_inc  = count_q + 16'd1;
	assign kept       = {1'b0, count_q} < 17'(BUFFER_BYTES);
	assign hunt_phase = (rx_byte == cfg.sync_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;

	always_comb begin
		phase_n  = phase_q;
		sum_a_n  = sum_a_q;
		sum_b_n  = sum_b_q;
		class_n  = class_q;
		id_n     = id_q;
		length_n = length_q;
		count_n  = count_q;

		res.status        = ST_NOTHING;
		res.payload_byte  = 8'd0;
		res.payload_index = 16'd0;
		res.payload_kept  = 1'b0;

		unique case (phase_q)
			PH_HUNT_SECOND: begin
				phase_n = (rx_byte == cfg.sync_second) ? PH_CLASS : hunt_phase;
			end
			PH_CLASS: begin
				class_n = rx_byte;
				sum_a_n = rx_byte;
				sum_b_n = rx_byte;
				phase_n = PH_ID;
			end
			PH_ID: begin
				sum_a_n = add_a;
				sum_b_n = add_b;
				id_n    = rx_byte;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				sum_a_n  = add_a;
				sum_b_n  = add_b;
				length_n = {8'd0, rx_byte};
				phase_n  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_a_n = add_a;
				sum_b_n = add_b;
				if (new_len > cfg.length_limit) begin
					// false sync: byte may itself start a preamble
					res.status = ST_TOO_LONG;
					length_n   = 16'd0;
					phase_n    = hunt_phase;
				end else begin
					length_n = new_len;
					count_n  = 16'd0;
					phase_n  = (new_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_a_n           = add_a;
				sum_b_n           = add_b;
				res.status        = ST_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
				res.payload_kept  = kept;
				count_n           = count_inc;
				if (count_inc == length_q) begin
					phase_n = PH_CK_A;
				end
			end
			PH_CK_A: begin
				if (rx_byte == sum_a_q) begin
					phase_n = PH_CK_B;
				end else begin
					res.status = ST_CK_A_BAD;
					phase_n    = hunt_phase;
				end
			end
			PH_CK_B: begin
				res.status = (rx_byte == sum_b_q) ? ST_GOOD : ST_CK_B_BAD;
				phase_n    = PH_HUNT_FIRST;
			end
			default: begin
				phase_n = hunt_phase;
			end
		endcase

		res.frame_class  = class_n;
		res.frame_id     = id_n;
		// a rejected header still reports the length it declared
		res.frame_length = (res.status == ST_TOO_LONG) ? new_len : length_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT_FIRST;
			sum_a_q  <= 8'd0;
			sum_b_q  <= 8'd0;
			class_q  <= 8'd0;
			id_q     <= 8'd0;
			length_q <= 16'd0;
			count_q  <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			sum_a_q  <= sum_a_n;
			sum_b_q  <= sum_b_n;
			class_q  <= class_n;
			id_q     <= id_n;
			length_q <= length_n;
			count_q  <= count_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sfpf8_out_buf.sv
`default_nettype none
module sfpf8_out_buf
	import sfpf8_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_res,
	output logic      space,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;
	logic take;
	logic out_free;

	assign take      = out_valid_q && out_ready;
	assign out_free  = !out_valid_q || take;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_res_q <= skid_res_q;
			end
		end else if (push) begin
			if (out_free) begin
				out_res_q <= push_res;
			end else begin
				skid_res_q <= push_res;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sync_frame_parser_fletcher8_core.sv
// byte-serial frame parser with an 8-bit fletcher checksum
// input channel: in_valid / in_ready carry one received byte (rx_byte) per request
// output channel: out_valid / out_ready carry exactly one result per input byte:
//   status, payload byte with its index and kept flag, and the current header fields
// the parser state (phase, sums, header, payload count) updates in the cycle a byte
//   is accepted and the result is registered at that same edge; a new byte can be taken
//   in every cycle while the skid register is empty
// the result side is an output register plus one skid register: a byte is still taken
//   while one result waits, and in_ready drops only once both hold results
// with out_ready held low, at most two results queue up, then input stalls
// configuration: apb port, sync_first at 0x0, sync_second at 0x4, length_limit at 0x8,
//   pready always high, writes land on the access cycle and act on the next byte
// reset (arst_n low) restores the register defaults, returns the parser to hunting
//   the first preamble byte with cleared sums and header, and empties both result stages
`default_nettype none
module sync_frame_parser_fletcher8_core
	import sfpf8_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [2:0]  status,
	output logic      [7:0]  payload_byte,
	output logic      [15:0] payload_index,
	output logic             payload_kept,
	output logic      [7:0]  frame_class,
	output logic      [7:0]  frame_id,
	output logic      [15:0] frame_length,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t cfg;
	res_t step_res;
	res_t out_res;
	logic space;
	logic accept;

	// a byte is taken whenever the skid register is empty
	assign in_ready = space;
	assign accept   = in_valid && space;

	sfpf8_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// per-byte state update and result formation
	sfpf8_parser #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.res     (step_res)
	);

	// result register with skid stage
	sfpf8_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_res  (step_res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign status        = out_res.status;
	assign payload_byte  = out_res.payload_byte;
	assign payload_index = out_res.payload_index;
	assign payload_kept  = out_res.payload_kept;
	assign frame_class   = out_res.frame_class;
	assign frame_id      = out_res.frame_id;
	assign frame_length  = out_res.frame_length;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import sfpf8_pkg::*;

	localparam int BUFFER_BYTES = 256;
	// generous ceiling on the run length, many times over what the requests need
	localparam int CYCLE_LIMIT = 400000;
	// room to register a result and pass it through the skid stage, with margin
	localparam int TAIL_CYCLES = 8;

	// how the stimulus shapes one frame
	typedef enum int {FK_GOOD, FK_BAD_A, FK_BAD_B, FK_TOO_LONG, FK_CUT} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic        payload_kept;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [15:0] frame_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// configuration as the parser should currently see it
	logic [7:0]  cur_sync_first = SYNC_FIRST_RST;
	logic [7:0]  cur_sync_second = SYNC_SECOND_RST;
	logic [15:0] cur_length_limit = LENGTH_LIMIT_RST;

	// predicted parser state, all zero out of reset
	phase_t      prs_phase = PH_HUNT_FIRST;
	logic [7:0]  fl_sum_a = 8'h00;
	logic [7:0]  fl_sum_b = 8'h00;
	logic [7:0]  hdr_class = 8'h00;
	logic [7:0]  hdr_id = 8'h00;
	logic [15:0] hdr_length = 16'h0000;
	logic [15:0] pay_count = 16'h0000;

	// predicted frame reports, oldest first
	res_t pending_reports[$];

	int unsigned send_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	// bytes sent as part of frames in the random part
	int unsigned frame_bytes = 0;

	sync_frame_parser_fletcher8_core #(.BUFFER_BYTES(BUFFER_BYTES)) u_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
		mismatch_count++;
	endtask

	// one step of the 8-bit fletcher sums, packed as {sum_b, sum_a}
	function automatic logic [15:0] fletcher_fold(input logic [15:0] sums, input logic [7:0] x);
		logic [7:0] a;
		logic [7:0] b;
		a = sums[7:0] + x;
		b = sums[15:8] + a;
		return {b, a};
	endfunction

	// a byte that breaks the header is looked at again as a possible preamble start
	function automatic phase_t first_hunt_phase(input logic [7:0] x);
		if (x == cur_sync_first)
			return PH_HUNT_SECOND;
		return PH_HUNT_FIRST;
	endfunction

	// advances the predicted parser by one byte and returns the report it should give
	function automatic res_t parse_byte(input logic [7:0] x);
		res_t r;
		logic [15:0] declared;
		logic too_long;
		r = '0;
		r.status = ST_NOTHING;
		declared = 16'h0000;
		too_long = 1'b0;
		case (prs_phase)
			PH_HUNT_SECOND: begin
				if (x == cur_sync_second)
					prs_phase = PH_CLASS;
				else
					prs_phase = first_hunt_phase(x);
			end
			PH_CLASS: begin
				hdr_class = x;
				fl_sum_a = x;
				fl_sum_b = x;
				prs_phase = PH_ID;
			end
			PH_ID: begin
				{fl_sum_b, fl_sum_a} = fletcher_fold({fl_sum_b, fl_sum_a}, x);
				hdr_id = x;
				prs_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				{fl_sum_b, fl_sum_a} = fletcher_fold({fl_sum_b, fl_sum_a}, x);
				hdr_length = {8'h00, x};
				prs_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				{fl_sum_b, fl_sum_a} = fletcher_fold({fl_sum_b, fl_sum_a}, x);
				hdr_length[15:8] = x;
				if (hdr_length > cur_length_limit) begin
					// false sync: report the declared length, then hunt again
					r.status = ST_TOO_LONG;
					declared = hdr_length;
					too_long = 1'b1;
					hdr_length = 16'h0000;
					prs_phase = first_hunt_phase(x);
				end else begin
					pay_count = 16'h0000;
					if (hdr_length == 16'h0000)
						prs_phase = PH_CK_A;
					else
						prs_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				{fl_sum_b, fl_sum_a} = fletcher_fold({fl_sum_b, fl_sum_a}, x);
				r.status = ST_PAYLOAD;
				r.payload_byte = x;
				r.payload_index = pay_count;
				r.payload_kept = (pay_count < BUFFER_BYTES);
				pay_count = pay_count + 16'd1;
				if (pay_count == hdr_length)
					prs_phase = PH_CK_A;
			end
			PH_CK_A: begin
				if (x == fl_sum_a) begin
					prs_phase = PH_CK_B;
				end else begin
					r.status = ST_CK_A_BAD;
					prs_phase = first_hunt_phase(x);
				end
			end
			PH_CK_B: begin
				if (x == fl_sum_b)
					r.status = ST_GOOD;
				else
					r.status = ST_CK_B_BAD;
				prs_phase = PH_HUNT_FIRST;
			end
			default: begin
				prs_phase = first_hunt_phase(x);
			end
		endcase
		r.frame_class = hdr_class;
		r.frame_id = hdr_id;
		r.frame_length = too_long ? declared : hdr_length;
		return r;
	endfunction

	task automatic check_report(input res_t got, input res_t want);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.payload_byte !== want.payload_byte)
			report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
		if (got.payload_index !== want.payload_index)
			report_mismatch("payload_index", 32'(got.payload_index),
				32'(want.payload_index));
		if (got.payload_kept !== want.payload_kept)
			report_mismatch("payload_kept", 32'(got.payload_kept), 32'(want.payload_kept));
		if (got.frame_class !== want.frame_class)
			report_mismatch("frame_class", 32'(got.frame_class), 32'(want.frame_class));
		if (got.frame_id !== want.frame_id)
			report_mismatch("frame_id", 32'(got.frame_id), 32'(want.frame_id));
		if (got.frame_length !== want.frame_length)
			report_mismatch("frame_length", 32'(got.frame_length), 32'(want.frame_length));
	endtask

	// scoreboard: results are checked before the byte taken at the same edge is predicted,
	// since a result always belongs to an earlier request
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status = status_t'(status);
				got.payload_byte = payload_byte;
				got.payload_index = payload_index;
				got.payload_kept = payload_kept;
				got.frame_class = frame_class;
				got.frame_id = frame_id;
				got.frame_length = frame_length;
				if (pending_reports.size() == 0)
					report_mismatch("unexpected result, status", 32'(got.status), 32'd0);
				else
					check_report(got, pending_reports.pop_front());
			end
			if (in_valid && in_ready)
				pending_reports.push_back(parse_byte(rx_byte));
		end
	end

	// sends one byte; valid only drops when a gap is taken before the next request
	task automatic send_byte(input logic [7:0] x);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= x;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_bytes(input logic [7:0] q[$], input int first);
		for (int i = first; i < q.size(); i++)
			send_byte(q[i]);
	endtask

	// stop sending and wait for every predicted report to come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	// one apb transfer: setup, access, then an idle cycle
	task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [31:0] got);
		case (idx)
			REG_SYNC_FIRST: begin
				if (got[7:0] !== cur_sync_first)
					report_mismatch("sync_first readback", 32'(got[7:0]),
						32'(cur_sync_first));
			end
			REG_SYNC_SECOND: begin
				if (got[7:0] !== cur_sync_second)
					report_mismatch("sync_second readback", 32'(got[7:0]),
						32'(cur_sync_second));
			end
			default: begin
				if (got[15:0] !== cur_length_limit)
					report_mismatch("length_limit readback", 32'(got[15:0]),
						32'(cur_length_limit));
			end
		endcase
	endtask

	// write a register, note it for the predictor and read it back
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] back;
		apb_cycle(1'b1, idx, val, back);
		case (idx)
			REG_SYNC_FIRST:   cur_sync_first = val[7:0];
			REG_SYNC_SECOND:  cur_sync_second = val[7:0];
			REG_LENGTH_LIMIT: cur_length_limit = val[15:0];
			default: ;
		endcase
		apb_cycle(1'b0, idx, 32'h0, back);
		check_register(idx, back);
	endtask

	task automatic apply_config(input logic [31:0] sf, input logic [31:0] ss,
			input logic [31:0] lim);
		wait_drained();
		cfg_write(REG_SYNC_FIRST, sf);
		cfg_write(REG_SYNC_SECOND, ss);
		cfg_write(REG_LENGTH_LIMIT, lim);
	endtask

	// builds the bytes of one frame under the current preamble; with sync_tail set, a
	// bad checksum a byte is made equal to the first preamble byte where possible
	function automatic void build_frame(input frame_kind_t kind, input logic [7:0] cls,
			input logic [7:0] id, input logic [15:0] len, input bit sync_tail,
			output logic [7:0] q[$]);
		logic [15:0] sums;
		logic [7:0] x;
		q = {};
		q.push_back(cur_sync_first);
		q.push_back(cur_sync_second);
		q.push_back(cls);
		q.push_back(id);
		q.push_back(len[7:0]);
		q.push_back(len[15:8]);
		sums = {cls, cls};
		sums = fletcher_fold(sums, id);
		sums = fletcher_fold(sums, len[7:0]);
		sums = fletcher_fold(sums, len[15:8]);
		if (kind == FK_TOO_LONG)
			return;
		for (int i = 0; i < len; i++) begin
			x = 8'($urandom_range(255));
			q.push_back(x);
			sums = fletcher_fold(sums, x);
		end
		case (kind)
			FK_BAD_A: begin
				if (sync_tail && sums[7:0] != cur_sync_first)
					q.push_back(cur_sync_first);
				else
					q.push_back(sums[7:0] ^ 8'($urandom_range(255, 1)));
			end
			FK_BAD_B: begin
				q.push_back(sums[7:0]);
				q.push_back(sums[15:8] ^ 8'($urandom_range(255, 1)));
			end
			default: begin
				q.push_back(sums[7:0]);
				q.push_back(sums[15:8]);
			end
		endcase
		// a cut frame stops somewhere short of its last byte
		if (kind == FK_CUT)
			q = q[0:$urandom_range(q.size() - 2)];
	endfunction

	// payload lengths stay short; rarely one runs past the buffer
	function automatic logic [15:0] pick_length(input frame_kind_t kind, input bit sync_tail);
		logic [15:0] n;
		if (kind == FK_TOO_LONG) begin
			n = {cur_sync_first, 8'($urandom_range(255))};
			if (!sync_tail || n <= cur_length_limit)
				n = 16'($urandom_range(65535, cur_length_limit + 1));
			return n;
		end
		if ($urandom_range(9) == 0)
			return 16'h0000;
		if (cur_length_limit >= 300 && $urandom_range(99) < 2)
			return 16'($urandom_range(300, 256));
		if (cur_length_limit < 24)
			return 16'($urandom_range(cur_length_limit));
		return 16'($urandom_range(24));
	endfunction

	task automatic randomise_config();
		logic [31:0] sf;
		logic [31:0] ss;
		logic [15:0] lim;
		sf = $urandom();
		ss = ($urandom_range(9) == 0) ? sf : $urandom();
		case ($urandom_range(4))
			0: lim = 16'h0000;
			1: lim = 16'hFFFF;
			2: lim = 16'($urandom_range(40));
			3: lim = 16'($urandom_range(65535));
			default: lim = LENGTH_LIMIT_RST;
		endcase
		apply_config(sf, ss, {16'($urandom_range(65535)), lim});
	endtask

	task automatic test_register_defaults();
		logic [1:0] regs[3] = '{REG_SYNC_FIRST, REG_SYNC_SECOND, REG_LENGTH_LIMIT};
		logic [31:0] back;
		foreach (regs[i]) begin
			apb_cycle(1'b0, regs[i], 32'h0, back);
			check_register(regs[i], back);
		end
	endtask

	// header extremes and a frame with no payload
	task automatic test_good_frames();
		logic [7:0] q[$];
		build_frame(FK_GOOD, 8'hFF, 8'h00, 16'd1, 1'b0, q);
		send_bytes(q, 0);
		build_frame(FK_GOOD, 8'h00, 8'hFF, 16'd0, 1'b0, q);
		send_bytes(q, 0);
		wait_drained();
	endtask

	// a wrong second byte, then the first byte twice in a row
	task automatic test_preamble_mismatch();
		logic [7:0] q[$];
		send_byte(cur_sync_first);
		send_byte(8'h00);
		send_byte(cur_sync_first);
		build_frame(FK_GOOD, 8'h5A, 8'hA5, 16'd0, 1'b0, q);
		send_bytes(q, 0);
		wait_drained();
	endtask

	// a bad checksum a byte that is itself a preamble start, then a bad checksum b
	task automatic test_checksum_errors();
		logic [7:0] q[$];
		build_frame(FK_BAD_A, 8'h01, 8'h02, 16'd0, 1'b1, q);
		send_bytes(q, 0);
		build_frame(FK_GOOD, 8'h03, 8'h04, 16'd0, 1'b0, q);
		send_bytes(q, 1);
		build_frame(FK_BAD_B, 8'h05, 8'h06, 16'd1, 1'b0, q);
		send_bytes(q, 0);
		wait_drained();
	endtask

	// declared length over the limit whose high byte restarts the preamble
	task automatic test_length_limit();
		logic [7:0] q[$];
		build_frame(FK_TOO_LONG, 8'h11, 8'h22, {cur_sync_first, 8'h00}, 1'b1, q);
		send_bytes(q, 0);
		build_frame(FK_GOOD, 8'h33, 8'h44, 16'd2, 1'b0, q);
		send_bytes(q, 1);
		wait_drained();
	endtask

	task automatic test_config_extremes();
		logic [7:0] q[$];
		// limit zero: only empty frames pass
		apply_config(32'h0000_0000, 32'h0000_00FF, 32'h0000_0000);
		build_frame(FK_GOOD, 8'h80, 8'h7F, 16'd0, 1'b0, q);
		send_bytes(q, 0);
		build_frame(FK_TOO_LONG, 8'h81, 8'h7E, 16'd1, 1'b0, q);
		send_bytes(q, 0);
		// widest limit with a payload that runs past the buffer
		apply_config(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
		build_frame(FK_GOOD, 8'hC3, 8'h3C, 16'd300, 1'b0, q);
		send_bytes(q, 0);
		// equal preamble bytes, limit one
		apply_config(32'h0000_005A, 32'h0000_005A, 32'h0000_0001);
		send_byte(8'h5A);
		build_frame(FK_GOOD, 8'h12, 8'h34, 16'd1, 1'b0, q);
		send_bytes(q, 0);
		build_frame(FK_TOO_LONG, 8'h56, 8'h78, 16'd2, 1'b0, q);
		send_bytes(q, 0);
		apply_config(32'(SYNC_FIRST_RST), 32'(SYNC_SECOND_RST), 32'(LENGTH_LIMIT_RST));
	endtask

	// mostly well-formed frames with random content, broken ones and line noise mixed in
	task automatic test_random_traffic(input int unsigned n_bytes);
		int unsigned goal;
		int unsigned next_cfg;
		int unsigned pick;
		bit skip_sync;
		bit tail;
		frame_kind_t kind;
		logic [7:0] q[$];
		goal = frame_bytes + n_bytes;
		next_cfg = frame_bytes + 110;
		skip_sync = 1'b0;
		while (frame_bytes < goal) begin
			if (frame_bytes >= next_cfg) begin
				randomise_config();
				next_cfg = frame_bytes + 110;
				skip_sync = 1'b0;
			end
			pick = $urandom_range(99);
			tail = 1'($urandom_range(1));
			if (pick < 8) begin
				repeat ($urandom_range(4, 1))
					send_byte(($urandom_range(3) == 0) ? cur_sync_first
						: 8'($urandom_range(255)));
				skip_sync = 1'b0;
				continue;
			end
			if (pick < 62)
				kind = FK_GOOD;
			else if (pick < 71)
				kind = FK_BAD_A;
			else if (pick < 80)
				kind = FK_BAD_B;
			else if (pick < 90)
				kind = FK_TOO_LONG;
			else
				kind = FK_CUT;
			if (kind == FK_TOO_LONG && cur_length_limit == 16'hFFFF)
				kind = FK_GOOD;
			build_frame(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
				pick_length(kind, tail), tail, q);
			send_bytes(q, int'(skip_sync));
			frame_bytes += q.size() - int'(skip_sync);
			// the parser already holds the first preamble byte if the frame ended on one
			skip_sync = (kind == FK_BAD_A || kind == FK_TOO_LONG)
				&& q[q.size() - 1] == cur_sync_first;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender gaps lighter than receiver stalls
		send_idle_pct = 36;
		sink_stall_pct = 46;
		test_register_defaults();
		test_good_frames();
		test_preamble_mismatch();
		test_checksum_errors();
		test_length_limit();
		test_config_extremes();
		test_random_traffic(400);

		// the other way round
		send_idle_pct = 46;
		sink_stall_pct = 36;
		test_random_traffic(400);

		// full rate on both sides
		send_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_traffic(400);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0)
			report_mismatch("results never delivered, count", pending_reports.size(), 0);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
